FILE: sv/blob_centroid_tracker_macros.svh
// assertion macros for the blob centroid tracker
// used by blob_centroid_tracker.sv; expects clk_i and rst_ni in scope
`ifndef BLOB_CENTROID_TRACKER_MACROS_SVH
`define BLOB_CENTROID_TRACKER_MACROS_SVH

`ifndef SYNTH
// check that is switched off while reset is asserted
`define BCT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("blob centroid tracker check failed");
// check that holds through reset as well
`define BCT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("blob centroid tracker check failed");
`else
`define BCT_ASSERT(lbl, prop)
`define BCT_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

FILE: sv/bct_pkg.sv
// shared types and constants of the blob centroid tracker
// no dependencies; imported by blob_centroid_tracker
package bct_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int POS_W  = $clog2(MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT);
  localparam int WID_W  = 11;                 // image_width register
  localparam int COEF_W = 17;                 // smoothing_coeff register
  localparam int CFG_W  = 17;                 // widest register
  localparam int SUM_W  = 40;
  localparam int CNT_W  = 21;
  localparam int FRAC_W = 16;
  localparam int AVG_W  = CNT_W + FRAC_W;     // Q21.16
  localparam int CEN_W  = 10;
  localparam int PCT_W  = 13;
  localparam int ALU_W  = AVG_W + COEF_W + 2; // product plus headroom
  localparam int STEP_W = $clog2(SUM_W);
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;

  localparam logic [COEF_W-1:0] Q16_ONE  = COEF_W'(1) << FRAC_W;
  localparam logic [CEN_W-1:0]  CEN_MAX  = '1;
  localparam logic [PCT_W-1:0]  PCT_MAX  = '1;
  localparam logic [PCT_W-1:0]  PCT_BIAS = PCT_W'(2);

  localparam logic [WID_W-1:0]  WIDTH_RESET = WID_W'(640);
  localparam logic [COEF_W-1:0] COEF_RESET  = COEF_W'(16384);

  // register indexes of the configuration port
  typedef enum logic {
    REG_IMAGE_WIDTH = 1'b0,
    REG_SMOOTH_COEF = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVX,
    ST_DIVY,
    ST_DELTA,
    ST_NEG,
    ST_MUL,
    ST_UPD,
    ST_DONE
  } state_e;

endpackage

FILE: sv/blob_centroid_tracker.sv
// blob centroid tracker: centroid and smoothed size of a binary mask stream
// depends on bct_pkg and blob_centroid_tracker_macros.svh

// The block takes a thresholded mask one pixel per item in raster order
// (s_axis_tdata[0] = pixel set, s_axis_tlast = last pixel of the frame) and
// gives one result item per frame: the centroid column and row (sum of the
// set-pixel positions over a count that starts at 1, truncated and clamped to
// 1023) and a size figure, floor(average / 2^24) + 2 clamped to 8191, where
// the average is an exponential moving average of the count in Q21.16 with
// the Q16 weight smoothing_coeff. A pixel that is not a frame end leaves the
// block idle, so a frame streams at one pixel per clock. A frame-end item
// keeps s_axis_tready low while a single 56-bit add/subtract unit does the
// frame-end arithmetic: two 40-step restoring divisions, a difference state
// and, when the average is falling, a negate state to form the magnitude of
// the average error, a 17-step shift-add multiply by the weight, one update
// step and a final state that loads the output register. That final state
// waits as long as the previous result is still unread, so a stalled receiver
// stalls the input too. The result sits in an output register, so the next
// frame can start while it waits to be taken. Configuration is written
// through cfg_we_i / cfg_addr_i / cfg_data_i; an image_width of 0 acts as 1,
// above 1024 as 1024, and a weight above 65536 acts as 1.0.
`include "blob_centroid_tracker_macros.svh"

module blob_centroid_tracker
  import bct_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write port
  input  logic                   cfg_we_i,
  input  logic                   cfg_addr_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  // mask pixel stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [0] pixel_set, rest zero
  input  logic                   s_axis_tlast,  // frame_end
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata   // [9:0] centroid_col, [19:10] centroid_row,
                                                // [32:20] size_percent, rest zero
);

  // control and frame state
  state_e              state_q, state_d;
  logic [WID_W-1:0]    width_q;
  logic [COEF_W-1:0]   coeff_q;
  logic [POS_W-1:0]    col_q, col_d;
  logic [POS_W-1:0]    row_q, row_d;
  logic [SUM_W-1:0]    sum_x_q, sum_x_d;
  logic [SUM_W-1:0]    sum_y_q, sum_y_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [AVG_W-1:0]    avg_q, avg_d;
  logic [STEP_W-1:0]   cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;

  // working registers of the shared unit
  logic [CNT_W-1:0]    rem_q, rem_d;
  logic [CEN_W-1:0]    quo_q, quo_d;
  logic                ovf_q, ovf_d;
  logic [CEN_W-1:0]    res_x_q, res_x_d;
  logic [CEN_W-1:0]    res_y_q, res_y_d;
  logic                neg_q, neg_d;
  logic [AVG_W-1:0]    mag_q, mag_d;
  logic [ALU_W-1:0]    acc_q, acc_d;

  // result register
  logic [CEN_W-1:0]    out_cx_q, out_cx_d;
  logic [CEN_W-1:0]    out_cy_q, out_cy_d;
  logic [PCT_W-1:0]    out_pct_q, out_pct_d;

  // shared add/subtract unit, the top bit is the borrow of a subtract
  logic [ALU_W-1:0]    alu_a, alu_b;
  logic                alu_sub;
  logic [ALU_W:0]      alu_res;

  logic                in_acc, out_acc, pix_set;
  logic [WID_W-1:0]    eff_width;
  logic [COEF_W-1:0]   eff_coeff;
  logic [POS_W:0]      col_inc;
  logic [SUM_W:0]      sum_x_add, sum_y_add;
  logic [CNT_W:0]      count_add;
  logic                div_msb;
  logic [CNT_W:0]      rem_sh;
  logic                q_bit;
  logic [CEN_W-1:0]    q_next;
  logic                ovf_next;
  logic [CEN_W-1:0]    q_final;
  logic [AVG_W-1:0]    target;
  logic [PCT_W:0]      pct_sum;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = out_valid_q && m_axis_tready;
  assign pix_set = s_axis_tdata[0];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_W-CEN_W-CEN_W-PCT_W)'(0), out_pct_q, out_cy_q, out_cx_q};

  // out-of-range register values
  always_comb begin
    priority if (width_q == '0) begin
      eff_width = WID_W'(1);
    end else if (width_q > WID_W'(MAX_WIDTH)) begin
      eff_width = WID_W'(MAX_WIDTH);
    end else begin
      eff_width = width_q;
    end
  end

  assign eff_coeff = coeff_q[FRAC_W] ? Q16_ONE : coeff_q;

  assign alu_res = {1'b0, alu_a} + (alu_sub ? -{1'b0, alu_b} : {1'b0, alu_b});

  assign col_inc   = {1'b0, col_q} + (POS_W+1)'(1);
  assign sum_x_add = {1'b0, sum_x_q} + (SUM_W+1)'(col_q);
  assign sum_y_add = {1'b0, sum_y_q} + (SUM_W+1)'(row_q);
  assign count_add = {1'b0, count_q} + (CNT_W+1)'(1);

  // divider step: bring down the next dividend bit, keep the quotient low bits
  assign div_msb  = (state_q == ST_DIVX) ? sum_x_q[SUM_W-1] : sum_y_q[SUM_W-1];
  assign rem_sh   = {rem_q, div_msb};
  assign q_bit    = !alu_res[ALU_W];
  assign q_next   = {quo_q[CEN_W-2:0], q_bit};
  assign ovf_next = ovf_q | quo_q[CEN_W-1];
  assign q_final  = ovf_next ? CEN_MAX : q_next;

  assign target  = {count_q, FRAC_W'(0)};
  assign pct_sum = {1'b0, avg_q[AVG_W-1:AVG_W-PCT_W]} + (PCT_W+1)'(PCT_BIAS);

  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    row_d       = row_q;
    sum_x_d     = sum_x_q;
    sum_y_d     = sum_y_q;
    count_d     = count_q;
    avg_d       = avg_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    ovf_d       = ovf_q;
    res_x_d     = res_x_q;
    res_y_d     = res_y_q;
    neg_d       = neg_q;
    mag_d       = mag_q;
    acc_d       = acc_q;
    out_cx_d    = out_cx_q;
    out_cy_d    = out_cy_q;
    out_pct_d   = out_pct_q;
    out_valid_d = out_valid_q && !out_acc;
    alu_a       = '0;
    alu_b       = '0;
    alu_sub     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          // accumulate, saturating
          if (pix_set) begin
            sum_x_d = sum_x_add[SUM_W] ? '1 : sum_x_add[SUM_W-1:0];
            sum_y_d = sum_y_add[SUM_W] ? '1 : sum_y_add[SUM_W-1:0];
            count_d = count_add[CNT_W] ? '1 : count_add[CNT_W-1:0];
          end
          if (s_axis_tlast) begin
            state_d = ST_DIVX;
            rem_d   = '0;
            quo_d   = '0;
            ovf_d   = 1'b0;
            cnt_d   = STEP_W'(SUM_W - 1);
          end else if (col_inc >= (POS_W+1)'(eff_width)) begin
            col_d = '0;
            if (row_q < POS_W'(MAX_HEIGHT - 1)) begin
              row_d = row_q + POS_W'(1);
            end
          end else begin
            col_d = col_inc[POS_W-1:0];
          end
        end
      end

      ST_DIVX, ST_DIVY: begin
        alu_a   = ALU_W'(rem_sh);
        alu_b   = ALU_W'(count_q);
        alu_sub = 1'b1;
        rem_d   = q_bit ? alu_res[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        quo_d   = q_next;
        ovf_d   = ovf_next;
        cnt_d   = cnt_q - STEP_W'(1);
        if (state_q == ST_DIVX) begin
          sum_x_d = {sum_x_q[SUM_W-2:0], 1'b0};
        end else begin
          sum_y_d = {sum_y_q[SUM_W-2:0], 1'b0};
        end
        if (cnt_q == '0) begin
          rem_d = '0;
          quo_d = '0;
          ovf_d = 1'b0;
          if (state_q == ST_DIVX) begin
            res_x_d = q_final;
            cnt_d   = STEP_W'(SUM_W - 1);
            state_d = ST_DIVY;
          end else begin
            res_y_d = q_final;
            state_d = ST_DELTA;
          end
        end
      end

      // error of the average, sign first
      ST_DELTA: begin
        alu_a   = ALU_W'(target);
        alu_b   = ALU_W'(avg_q);
        alu_sub = 1'b1;
        neg_d   = alu_res[ALU_W];
        mag_d   = alu_res[AVG_W-1:0];
        acc_d   = '0;
        cnt_d   = STEP_W'(COEF_W - 1);
        state_d = alu_res[ALU_W] ? ST_NEG : ST_MUL;
      end

      ST_NEG: begin
        alu_a   = ALU_W'(avg_q);
        alu_b   = ALU_W'(target);
        alu_sub = 1'b1;
        mag_d   = alu_res[AVG_W-1:0];
        state_d = ST_MUL;
      end

      // magnitude times weight, weight bits from the top
      ST_MUL: begin
        alu_a   = {acc_q[ALU_W-2:0], 1'b0};
        alu_b   = eff_coeff[cnt_q[$clog2(COEF_W)-1:0]] ? ALU_W'(mag_q) : '0;
        acc_d   = alu_res[ALU_W-1:0];
        cnt_d   = cnt_q - STEP_W'(1);
        if (cnt_q == '0) begin
          state_d = ST_UPD;
        end
      end

      // step is truncated toward zero: magnitude shifted, sign applied here
      ST_UPD: begin
        alu_a   = ALU_W'(avg_q);
        alu_b   = ALU_W'(acc_q[ALU_W-1:FRAC_W]);
        alu_sub = neg_q;
        avg_d   = (neg_q && alu_res[ALU_W]) ? '0 : alu_res[AVG_W-1:0];
        state_d = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_cx_d    = res_x_q;
          out_cy_d    = res_y_q;
          out_pct_d   = pct_sum[PCT_W] ? PCT_MAX : pct_sum[PCT_W-1:0];
          out_valid_d = 1'b1;
          col_d       = '0;
          row_d       = '0;
          sum_x_d     = '0;
          sum_y_d     = '0;
          count_d     = CNT_W'(1);
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state, configuration and frame accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      width_q     <= WIDTH_RESET;
      coeff_q     <= COEF_RESET;
      col_q       <= '0;
      row_q       <= '0;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      count_q     <= CNT_W'(1);
      avg_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      sum_x_q     <= sum_x_d;
      sum_y_q     <= sum_y_d;
      count_q     <= count_d;
      avg_q       <= avg_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_addr_i))
          REG_IMAGE_WIDTH: width_q <= cfg_data_i[WID_W-1:0];
          REG_SMOOTH_COEF: coeff_q <= cfg_data_i[COEF_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // working and result registers
  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    ovf_q     <= ovf_d;
    res_x_q   <= res_x_d;
    res_y_q   <= res_y_d;
    neg_q     <= neg_d;
    mag_q     <= mag_d;
    acc_q     <= acc_d;
    out_cx_q  <= out_cx_d;
    out_cy_q  <= out_cy_d;
    out_pct_q <= out_pct_d;
  end

  // the divisor never reaches zero, also across reset
  `BCT_ASSERT_ALWAYS(a_count_nonzero, (!rst_ni || (count_q != '0)))

  // a frame end starts the first division
  `BCT_ASSERT(a_frame_end_divides, (in_acc && s_axis_tlast) |=> (state_q == ST_DIVX))

  // partial remainder stays below the divisor
  `BCT_ASSERT(a_rem_below_count,
    ((state_q == ST_DIVX) || (state_q == ST_DIVY)) |-> (rem_q < count_q))

  // handing over a result clears the frame position
  `BCT_ASSERT(a_done_clears,
    ((state_q == ST_DONE) && (!out_valid_q || m_axis_tready)) |=>
      (m_axis_tvalid && (col_q == '0) && (row_q == '0) && (count_q == CNT_W'(1))))

endmodule

FILE: tb/blob_centroid_tracker_test.sv
// self-checking testbench for the blob centroid tracker: streams masks, checks centroid and size
// depends on bct_pkg and the blob_centroid_tracker top level
module blob_centroid_tracker_test
  import bct_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 110;     // long enough for the block to finish a frame end
  localparam int DRAIN_LIMIT   = 20000;
  localparam int RANDOM_ITEMS  = 270;
  localparam int MIN_FRAMES    = 12;
  localparam longint TIMEOUT_NS = 5000000;

  localparam longint unsigned SUM_LIMIT = (64'd1 << SUM_W) - 1;
  localparam longint unsigned CNT_LIMIT = (64'd1 << CNT_W) - 1;

  typedef struct packed {
    logic [CEN_W-1:0] cx;
    logic [CEN_W-1:0] cy;
    logic [PCT_W-1:0] pct;
  } centroid_t;

  // dut ports
  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic                   cfg_addr_i    = 1'b0;
  logic [CFG_W-1:0]       cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // [0] pixel_set, rest zero
  logic                   s_axis_tlast  = 1'b0; // frame_end
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [9:0] centroid_col, [19:10] centroid_row,
                                                // [32:20] size_percent

  // model state of the tracker and its register copies
  logic [WID_W-1:0]  cfg_width = WIDTH_RESET;
  logic [COEF_W-1:0] cfg_coeff = COEF_RESET;
  longint unsigned   pos_col   = 0;
  longint unsigned   pos_row   = 0;
  longint unsigned   acc_x     = 0;
  longint unsigned   acc_y     = 0;
  longint unsigned   set_count = 1;
  longint unsigned   avg_count = 0;   // q21.16

  centroid_t centroid_q[$];

  int errors       = 0;
  int pixels_total = 0;
  int frames_total = 0;
  int results_seen = 0;
  int burst_left   = 0;
  int rx_hold_left = 0;   // set by a test, counted down by the receiver
  int rx_mode      = 0;
  int rx_mode_left = 0;

  blob_centroid_tracker uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // advance the tracker model by one pixel; emit is set on a frame end
  function automatic void track_pixel(input bit set, input bit last,
                                      output bit emit, output centroid_t res);
    longint unsigned eff_w, qx, qy, pct;
    longint signed   tgt, avg_s, coef_s, err, stp, nxt;
    emit = 1'b0;
    res  = '0;
    eff_w  = (cfg_width == 0) ? 64'd1 :
             (cfg_width > MAX_WIDTH) ? 64'(MAX_WIDTH) : 64'(cfg_width);
    coef_s = (cfg_coeff > Q16_ONE) ? 64'(Q16_ONE) : 64'(cfg_coeff);
    if (set) begin
      acc_x     = (acc_x + pos_col > SUM_LIMIT) ? SUM_LIMIT : acc_x + pos_col;
      acc_y     = (acc_y + pos_row > SUM_LIMIT) ? SUM_LIMIT : acc_y + pos_row;
      set_count = (set_count + 1 > CNT_LIMIT) ? CNT_LIMIT : set_count + 1;
    end
    if (last) begin
      qx = acc_x / set_count;
      qy = acc_y / set_count;
      if (qx > CEN_MAX) qx = 64'(CEN_MAX);
      if (qy > CEN_MAX) qy = 64'(CEN_MAX);
      // moving average: signed error times the weight, truncated toward zero
      tgt   = set_count << FRAC_W;
      avg_s = avg_count;
      err   = tgt - avg_s;
      stp   = (err * coef_s) / 64'sd65536;
      nxt   = avg_s + stp;
      if (nxt < 0) nxt = 0;
      avg_count = nxt;
      pct = (avg_count >> 24) + 64'(PCT_BIAS);
      if (pct > PCT_MAX) pct = 64'(PCT_MAX);
      res.cx  = qx[CEN_W-1:0];
      res.cy  = qy[CEN_W-1:0];
      res.pct = pct[PCT_W-1:0];
      emit    = 1'b1;
      pos_col   = 0;
      pos_row   = 0;
      acc_x     = 0;
      acc_y     = 0;
      set_count = 1;
    end else begin
      pos_col++;
      if (pos_col >= eff_w) begin
        pos_col = 0;
        if (pos_row < MAX_HEIGHT - 1) pos_row++;
      end
    end
  endfunction

  // offer one pixel in bursts with random gaps, then predict once accepted
  task automatic send_pixel(input bit set, input bit last);
    int        gap;
    bit        emit;
    centroid_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(set);
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    pixels_total++;
    track_pixel(set, last, emit, res);
    if (emit) begin
      centroid_q.push_back(res);
      frames_total++;
    end
  endtask

  // one frame of len pixels, each set with the given percent chance
  task automatic send_frame(input int len, input int density);
    for (int i = 0; i < len; i++)
      send_pixel($urandom_range(0, 99) < density, i == len - 1);
  endtask

  // stop offering and wait for every expected result plus the block's latency
  task automatic drain_results();
    int n;
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    n = 0;
    while (centroid_q.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk_i);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // both registers, one write after the other; block must be idle
  task automatic write_config(input logic [WID_W-1:0] width, input logic [COEF_W-1:0] coeff);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= REG_IMAGE_WIDTH;
    cfg_data_i <= CFG_W'(width);
    @(posedge clk_i);
    cfg_addr_i <= REG_SMOOTH_COEF;
    cfg_data_i <= CFG_W'(coeff);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_width = width;
    cfg_coeff = coeff;
  endtask

  // receiver: long hold when asked, otherwise a stall pattern of its own
  always @(posedge clk_i) begin
    if (rx_hold_left > 0) begin
      rx_hold_left = rx_hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 2);
        rx_mode_left = $urandom_range(16, 128);
      end
      rx_mode_left--;
      case (rx_mode)
        0: begin
          m_axis_tready <= 1'b1;
        end
        1: begin
          m_axis_tready <= 1'($urandom_range(0, 1));
        end
        default: begin
          m_axis_tready <= ($urandom_range(0, 3) == 0);
        end
      endcase
    end
  end

  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // result checker: every accepted item against the oldest expectation
  always @(posedge clk_i) begin
    centroid_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (centroid_q.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        exp_r = centroid_q.pop_front();
        check_field("centroid_col", int'(exp_r.cx), int'(m_axis_tdata[CEN_W-1:0]));
        check_field("centroid_row", int'(exp_r.cy), int'(m_axis_tdata[2*CEN_W-1:CEN_W]));
        check_field("size_percent", int'(exp_r.pct),
                    int'(m_axis_tdata[2*CEN_W+PCT_W-1:2*CEN_W]));
      end
    end
  end

  // reset values: width 640, weight 0.25; single-item frames and set/clear last pixels
  task automatic test_reset_defaults();
    send_pixel(1'b0, 1'b1);   // empty frame, count stays at one
    send_pixel(1'b1, 1'b1);   // one set pixel at the origin
    send_pixel(1'b1, 1'b0);
    send_pixel(1'b0, 1'b0);
    send_pixel(1'b1, 1'b0);
    send_pixel(1'b1, 1'b0);
    send_pixel(1'b1, 1'b1);   // set pixel on the frame end itself
    for (int i = 0; i < 9; i++) send_pixel(1'b1, 1'b0);
    send_pixel(1'b0, 1'b1);   // clear pixel on the frame end
    drain_results();
  endtask

  // width zero acts as one, then widths one, two and the maximum
  task automatic test_width_limits();
    write_config(WID_W'(0), COEF_W'(65536));
    send_frame(12, 70);
    drain_results();
    write_config(WID_W'(1), COEF_W'(32768));
    send_frame(8, 100);
    drain_results();
    write_config(WID_W'(2), COEF_W'(1));
    send_frame(9, 50);
    drain_results();
    write_config(WID_W'(1024), COEF_W'(65535));
    send_frame(30, 60);
    drain_results();
  endtask

  // long frame: rows saturate at the bottom; an oversized width with a clamped weight
  task automatic test_long_frames();
    write_config(WID_W'(1), COEF_W'(65536));
    for (int i = 0; i < 1030; i++)
      send_pixel(i >= 1015 || $urandom_range(0, 3) != 0, i == 1029);
    drain_results();
    write_config(WID_W'(2047), COEF_W'(131071));
    send_frame(40, 90);
    drain_results();
  endtask

  // weight zero freezes the average, an odd weight exercises truncation both ways, one above 65536 acts as 1.0
  task automatic test_coefficients();
    write_config(WID_W'(4), COEF_W'(65536));
    send_frame(40, 100);
    drain_results();
    write_config(WID_W'(4), COEF_W'(0));
    send_frame(5, 50);
    send_frame(3, 100);
    drain_results();
    write_config(WID_W'(5), COEF_W'(40001));
    send_frame(6, 50);
    send_frame(2, 0);
    drain_results();
    write_config(WID_W'(7), COEF_W'(98765));
    send_frame(60, 95);
    drain_results();
  endtask

  // receiver holds off long enough that a result waits unread and the next frame end stalls the input
  task automatic test_backpressure();
    write_config(WID_W'(3), COEF_W'(12345));
    rx_hold_left = 600;
    for (int f = 0; f < 5; f++) send_frame(3, 60);
    drain_results();
  endtask

  function automatic logic [WID_W-1:0] pick_width();
    case ($urandom_range(0, 9))
      0: return WID_W'(0);
      1: return WID_W'(1);
      2: return WID_W'(1024);
      3: return WID_W'(2047);
      4: return WID_W'($urandom_range(0, 2047));
      default: return WID_W'($urandom_range(2, 16));
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] pick_coeff();
    case ($urandom_range(0, 7))
      0: return COEF_W'(0);
      1: return COEF_W'(65536);
      2: return COEF_W'(131071);
      3: return COEF_W'($urandom_range(65537, 131071));
      default: return COEF_W'($urandom_range(1, 65535));
    endcase
  endfunction

  // random phases of a few frames each, registers changed between phases
  task automatic test_random_frames();
    int sent_start, phase_left, frames_start, len, density;
    sent_start   = pixels_total;
    frames_start = frames_total;
    phase_left   = 0;
    while (pixels_total - sent_start < RANDOM_ITEMS || frames_total - frames_start < MIN_FRAMES)
    begin
      if (phase_left == 0) begin
        drain_results();
        write_config(pick_width(), pick_coeff());
        phase_left = $urandom_range(3, 10);
      end
      if ($urandom_range(0, 99) < 85) begin
        len     = $urandom_range(1, 24);
        density = $urandom_range(0, 100);
      end else begin
        len     = $urandom_range(40, 120);
        density = $urandom_range(60, 100);
      end
      send_frame(len, density);
      phase_left--;
    end
    drain_results();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);
    test_reset_defaults();
    test_width_limits();
    test_long_frames();
    test_coefficients();
    test_backpressure();
    test_random_frames();
    if (centroid_q.size() != 0) begin
      $display("%0t: %0d results missing, expected more actual none", $time, centroid_q.size());
      errors += centroid_q.size();
    end
    $display("covered %0d pixels in %0d frames, %0d results checked, %0d errors",
             pixels_total, frames_total, results_seen, errors);
    $display("widths 0 to 2047, weights 0 to 131071, saturated rows and output stalls");
    if (errors == 0) begin
      $display("blob_centroid_tracker_test passed");
    end else begin
      $display("blob_centroid_tracker_test failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout with %0d results outstanding", $time, centroid_q.size());
    $display("blob_centroid_tracker_test failed");
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/bct_pkg.sv
sv/blob_centroid_tracker.sv
tb/blob_centroid_tracker_test.sv
